### hdl/rkd_pkg.sv
package rkd_pkg;

    // Field widths of the request and result items.
    localparam int PRIME_W = 16;
    localparam int EXP_W   = 16;
    localparam int RES_W   = 32;

    // Cofactor width: the Bezout coefficients stay within plus or minus the totient.
    localparam int COEF_W    = RES_W + 2;
    localparam int DIV_CNT_W = $clog2(RES_W);

    localparam int                 DEFAULT_FACTOR_WIDTH = 16;
    localparam logic [EXP_W-1:0]   EXP_RESET            = EXP_W'(7);

    typedef struct packed {
        logic [PRIME_W-1:0] prime_p;
        logic [PRIME_W-1:0] prime_q;
    } rkd_in_t;

    typedef struct packed {
        logic [RES_W-1:0] modulus;
        logic [RES_W-1:0] totient;
        logic [RES_W-1:0] private_exponent;
        logic             no_inverse;
    } rkd_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rkd_div_status_t;

endpackage

### hdl/rkd_div_unit.sv
module rkd_div_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rkd_pkg::RES_W-1:0]         dividend,
    input  logic [rkd_pkg::RES_W-1:0]         divisor,
    input  logic [rkd_pkg::COEF_W-1:0]        coef_prev,
    input  logic [rkd_pkg::COEF_W-1:0]        coef_cur,
    output rkd_pkg::rkd_div_status_t          status,
    output logic [rkd_pkg::RES_W-1:0]         remainder,
    output logic [rkd_pkg::COEF_W-1:0]        coef_new
);
    import rkd_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RES_W-1:0]       dvd_reg, dvd_next;
    logic [RES_W-1:0]       rem_reg, rem_next;
    logic [COEF_W-1:0]      acc_reg, acc_next;

    logic [RES_W:0]         rem_shift;
    logic [RES_W:0]         rem_diff;
    logic                   fits;

    // One restoring division step: shift in the next dividend bit and trial subtract.
    assign rem_shift = {rem_reg, dvd_reg[RES_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};
    assign fits      = rem_shift >= {1'b0, divisor};

    // Step control and datapath. The quotient is folded into the product with the
    // current cofactor by Horner's rule, most significant bit first.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[RES_W-2:0], 1'b0};
            rem_next = fits ? rem_diff[RES_W-1:0] : rem_shift[RES_W-1:0];
            acc_next = {acc_reg[COEF_W-2:0], 1'b0} + (fits ? coef_cur : '0);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(RES_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
    end

    // The new cofactor is the previous one minus quotient times the current one.
    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;
    assign coef_new    = coef_prev - acc_reg;

endmodule

### hdl/rsa_key_derivation_core.sv
// Channel   Signals                                Direction  Moves
// factor    factor_valid, factor_stall, factor     in         request with the primes p and q
// key       key_valid, key_stall, key              out        modulus, totient, d, no_inverse
// cfg       cfg_valid, cfg_ready, cfg_data         in         public exponent write
//
// Each request makes k Euclid steps, where k is the number of Euclid steps (at most about
// 48 for a 32-bit totient). Each step is one pass of the shared restoring divider, framed
// by the S_DIV_START and S_DIV_WAIT states of the sequencer.
// If the totient is below two, the request skips the Euclid steps and reports no inverse.
// Reset (rst_n low, asynchronous) clears the sequencer and sets the exponent to 7.
// A stalled result stays in the output register; the next request is taken meanwhile.
module rsa_key_derivation_core #(
    parameter int FACTOR_WIDTH = rkd_pkg::DEFAULT_FACTOR_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         factor_valid,
    output logic                         factor_stall,
    input  rkd_pkg::rkd_in_t             factor,
    output logic                         key_valid,
    input  logic                         key_stall,
    output rkd_pkg::rkd_out_t            key,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [rkd_pkg::EXP_W-1:0]    cfg_data
);
    import rkd_pkg::*;

    localparam int MASK_W = (FACTOR_WIDTH < PRIME_W) ? FACTOR_WIDTH : PRIME_W;
    localparam logic [PRIME_W-1:0] FACTOR_MASK = {PRIME_W{1'b1}} >> (PRIME_W - MASK_W);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_MUL_N     = 3'd1;
    localparam logic [2:0] S_MUL_R     = 3'd2;
    localparam logic [2:0] S_CHECK     = 3'd3;
    localparam logic [2:0] S_DIV_START = 3'd4;
    localparam logic [2:0] S_DIV_WAIT  = 3'd5;
    localparam logic [2:0] S_FINAL     = 3'd6;
    localparam logic [2:0] S_DONE      = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [EXP_W-1:0]     exponent_reg;
    logic [PRIME_W-1:0]   p_reg, p_next;
    logic [PRIME_W-1:0]   q_reg, q_next;
    logic [RES_W-1:0]     n_reg, n_next;
    logic [RES_W-1:0]     r_reg, r_next;
    logic [RES_W-1:0]     prev_rem_reg, prev_rem_next;
    logic [RES_W-1:0]     cur_rem_reg, cur_rem_next;
    logic [COEF_W-1:0]    prev_coef_reg, prev_coef_next;
    logic [COEF_W-1:0]    cur_coef_reg, cur_coef_next;
    logic [RES_W-1:0]     d_reg, d_next;
    logic                 none_reg, none_next;
    logic                 key_valid_reg, key_valid_next;
    rkd_out_t             key_reg, key_next;

    logic [PRIME_W-1:0]   mul_a;
    logic [PRIME_W-1:0]   mul_b;
    logic [RES_W-1:0]     mul_prod;
    logic [COEF_W-1:0]    coef_fixed;
    logic                 div_start;
    rkd_div_status_t      div_status;
    logic [RES_W-1:0]     div_rem;
    logic [COEF_W-1:0]    div_coef;

    // Exponent register; users send writes only while the block is idle; it is not enforced.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= EXP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            exponent_reg <= cfg_data;
        end
    end

    // Shared multiplier: p*q first, then (p-1)*(q-1).
    assign mul_a    = (state_reg == S_MUL_R) ? p_reg - 1'b1 : p_reg;
    assign mul_b    = (state_reg == S_MUL_R) ? q_reg - 1'b1 : q_reg;
    assign mul_prod = RES_W'(mul_a) * RES_W'(mul_b);

    // Shared divider for the Euclid steps.
    assign div_start = (state_reg == S_DIV_START);

    rkd_div_unit u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (prev_rem_reg),
        .divisor   (cur_rem_reg),
        .coef_prev (prev_coef_reg),
        .coef_cur  (cur_coef_reg),
        .status    (div_status),
        .remainder (div_rem),
        .coef_new  (div_coef)
    );

    // A negative cofactor is brought into range by adding the totient once.
    assign coef_fixed = prev_coef_reg[COEF_W-1] ? prev_coef_reg + COEF_W'(r_reg)
                                                : prev_coef_reg;

    assign factor_stall = (state_reg != S_IDLE);
    assign key_valid    = key_valid_reg;
    assign key          = key_reg;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        n_next         = n_reg;
        r_next         = r_reg;
        prev_rem_next  = prev_rem_reg;
        cur_rem_next   = cur_rem_reg;
        prev_coef_next = prev_coef_reg;
        cur_coef_next  = cur_coef_reg;
        d_next         = d_reg;
        none_next      = none_reg;
        key_next       = key_reg;
        key_valid_next = key_valid_reg;

        // The output register is freed when its result is taken.
        if (key_valid_reg && !key_stall)
        begin
            key_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (factor_valid)
                begin
                    p_next     = factor.prime_p & FACTOR_MASK;
                    q_next     = factor.prime_q & FACTOR_MASK;
                    state_next = S_MUL_N;
                end
            end
            S_MUL_N:
            begin
                n_next     = mul_prod;
                state_next = S_MUL_R;
            end
            S_MUL_R:
            begin
                r_next     = (p_reg == '0 || q_reg == '0) ? '0 : mul_prod;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // Starting from (e, r) makes the first step reduce e modulo r.
                if (r_reg < RES_W'(2))
                begin
                    d_next     = '0;
                    none_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    prev_rem_next  = RES_W'(exponent_reg);
                    cur_rem_next   = r_reg;
                    prev_coef_next = COEF_W'(1);
                    cur_coef_next  = '0;
                    state_next     = S_DIV_START;
                end
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    prev_rem_next  = cur_rem_reg;
                    cur_rem_next   = div_rem;
                    prev_coef_next = cur_coef_reg;
                    cur_coef_next  = div_coef;
                    state_next     = (div_rem == '0) ? S_FINAL : S_DIV_START;
                end
            end
            S_FINAL:
            begin
                if (prev_rem_reg == RES_W'(1))
                begin
                    d_next    = coef_fixed[RES_W-1:0];
                    none_next = 1'b0;
                end
                else
                begin
                    d_next    = '0;
                    none_next = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!key_valid_reg || !key_stall)
                begin
                    key_next.modulus          = n_reg;
                    key_next.totient          = r_reg;
                    key_next.private_exponent = d_reg;
                    key_next.no_inverse       = none_reg;
                    key_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_valid_reg <= key_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg         <= p_next;
        q_reg         <= q_next;
        n_reg         <= n_next;
        r_reg         <= r_next;
        prev_rem_reg  <= prev_rem_next;
        cur_rem_reg   <= cur_rem_next;
        prev_coef_reg <= prev_coef_next;
        cur_coef_reg  <= cur_coef_next;
        d_reg         <= d_next;
        none_reg      <= none_next;
        key_reg       <= key_next;
    end

    // The divider is never restarted while a division is still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    // The divisor is never zero during a division.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> cur_rem_reg != '0)
        else $error("division by zero in Euclid step");

    // A division only completes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> state_reg == S_DIV_WAIT)
        else $error("division finished outside the wait state");

    // A reported inverse lies in 1 .. totient-1.
    assert property (@(posedge clk) disable iff (!rst_n)
        (key_valid && !key.no_inverse) |->
            (key.private_exponent != '0 && key.private_exponent < key.totient))
        else $error("private exponent out of range");

endmodule

### dv/tb_rsa_key_derivation_core.sv
`timescale 1ns / 1ps

module tb_rsa_key_derivation_core;
    import rkd_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int N_CORNER    = 20;
    localparam int N_PHASES    = 8;

    // Scoreboard: derives the expected key for each accepted request and
    // compares it with the results in order.
    class key_scoreboard;
        rkd_out_t         expected_q[$];
        logic [EXP_W-1:0] exponent;
        int               errors;

        function new();
            exponent = EXP_RESET;
            errors   = 0;
        endfunction

        // Modulus, totient and the inverse of the exponent modulo the totient.
        function rkd_out_t derive_key(rkd_in_t req);
            rkd_out_t          res;
            longint unsigned   p;
            longint unsigned   q;
            longint unsigned   tot;
            longint            rem_a;
            longint            rem_b;
            longint            coef_a;
            longint            coef_b;
            longint            quo;
            longint            tmp;
            p   = longint'(req.prime_p);
            q   = longint'(req.prime_q);
            tot = 0;
            if (p != 0 && q != 0)
            begin
                tot = ((p - 1) * (q - 1)) & 64'hFFFF_FFFF;
            end
            res.modulus          = RES_W'((p * q) & 64'hFFFF_FFFF);
            res.totient          = RES_W'(tot);
            res.private_exponent = '0;
            res.no_inverse       = 1'b1;
            if (tot >= 2)
            begin
                // Extended Euclid, keeping only the coefficient of the exponent.
                rem_a  = longint'(tot);
                rem_b  = longint'(longint'(exponent) % tot);
                coef_a = 0;
                coef_b = 1;
                while (rem_b != 0)
                begin
                    quo    = rem_a / rem_b;
                    tmp    = rem_a - quo * rem_b;
                    rem_a  = rem_b;
                    rem_b  = tmp;
                    tmp    = coef_a - quo * coef_b;
                    coef_a = coef_b;
                    coef_b = tmp;
                end
                if (rem_a == 1)
                begin
                    if (coef_a < 0)
                    begin
                        coef_a = coef_a + longint'(tot);
                    end
                    res.private_exponent = RES_W'(coef_a);
                    res.no_inverse       = 1'b0;
                end
            end
            return res;
        endfunction

        function void note_request(rkd_in_t req);
            expected_q.push_back(derive_key(req));
        endfunction

        function void check_key(rkd_out_t got);
            rkd_out_t want;
            if (expected_q.size() == 0)
            begin
                $error("key result with no request outstanding");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.modulus !== want.modulus)
            begin
                $error("modulus: expected %0d, actual %0d", want.modulus, got.modulus);
                errors++;
            end
            if (got.totient !== want.totient)
            begin
                $error("totient: expected %0d, actual %0d", want.totient, got.totient);
                errors++;
            end
            if (got.private_exponent !== want.private_exponent)
            begin
                $error("private_exponent: expected %0d, actual %0d",
                       want.private_exponent, got.private_exponent);
                errors++;
            end
            if (got.no_inverse !== want.no_inverse)
            begin
                $error("no_inverse: expected %0d, actual %0d",
                       want.no_inverse, got.no_inverse);
                errors++;
            end
        endfunction
    endclass

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             factor_valid = 1'b0;
    logic             factor_stall;
    rkd_in_t          factor       = '0;
    logic             key_valid;
    logic             key_stall    = 1'b0;
    rkd_out_t         key;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic [EXP_W-1:0] cfg_data     = '0;

    key_scoreboard    key_sb;
    int               cycle_count  = 0;
    int               stall_mode   = 0;
    int               stall_left   = 0;

    // Corner requests: zero and unit factors, totients of one and two, an
    // exponent congruent to one, an exponent sharing a factor with the totient,
    // an exponent that is a multiple of the totient, and the largest factors.
    int corner_p [N_CORNER] = '{0, 0, 65535, 1, 1, 2, 2, 3, 2, 3,
                                65535, 65535, 32768, 43, 61, 65521, 43690, 21845, 2, 65535};
    int corner_q [N_CORNER] = '{0, 65535, 0, 1, 65535, 2, 3, 4, 8, 8,
                                65535, 65534, 32768, 59, 53, 65519, 21845, 43690, 65535, 2};

    // Exponent settings and request counts of the random phases; -1 picks a random exponent.
    int phase_exp [N_PHASES] = '{65535, 1, 0, 3, 257, -1, -1, -1};
    int phase_len [N_PHASES] = '{45, 15, 15, 45, 40, 40, 40, 30};

    rsa_key_derivation_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .factor_valid (factor_valid),
        .factor_stall (factor_stall),
        .factor       (factor),
        .key_valid    (key_valid),
        .key_stall    (key_stall),
        .key          (key),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // Watch both channels; values seen here are those from before the edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (factor_valid && !factor_stall)
            begin
                key_sb.note_request(factor);
            end
            if (key_valid && !key_stall)
            begin
                key_sb.check_key(key);
            end
        end
    end

    // Result stall pattern: stretches with no stall, light random stall and heavy stall.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(50, 600);
        end
        stall_left = stall_left - 1;
        case (stall_mode)
            0:       key_stall <= 1'b0;
            1:       key_stall <= ($urandom_range(0, 3) == 0);
            default: key_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Present one request and hold it until it is taken.
    task automatic send_factor(input logic [PRIME_W-1:0] p, input logic [PRIME_W-1:0] q);
        factor_valid   <= 1'b1;
        factor.prime_p <= p;
        factor.prime_q <= q;
        do
            @(posedge clk);
        while (factor_stall);
    endtask

    // Wait until every accepted request has produced its key.
    task automatic wait_drained();
        @(posedge clk);
        while (key_sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Exponent write, only while the core is idle.
    task automatic write_exponent(input logic [EXP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        key_sb.exponent = value;
    endtask

    // Factor choice: half odd prime-like values, some full range,
    // some small ones and some extremes.
    function automatic logic [PRIME_W-1:0] pick_factor();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
        begin
            return PRIME_W'($urandom_range(3, 65535) | 1);
        end
        else if (sel < 7)
        begin
            return PRIME_W'($urandom);
        end
        else if (sel < 9)
        begin
            return PRIME_W'($urandom_range(0, 50));
        end
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return PRIME_W'(1);
            2:       return PRIME_W'(2);
            3:       return PRIME_W'(65534);
            default: return '1;
        endcase
    endfunction

    // Random requests in bursts, with short gaps and now and then a long one
    // so that the core also drains and sits idle.
    task automatic run_random(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && sent < count)
            begin
                send_factor(pick_factor(), pick_factor());
                burst--;
                sent++;
            end
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 2000)
                                              : $urandom_range(0, 30);
            if (gap > 0)
            begin
                factor_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        factor_valid <= 1'b0;
    endtask

    // Main sequence: reset, corner requests under the reset exponent, then
    // random phases under several exponent settings.
    initial
    begin
        int value;
        key_sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_CORNER; i++)
        begin
            send_factor(PRIME_W'(corner_p[i]), PRIME_W'(corner_q[i]));
        end
        factor_valid <= 1'b0;

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wait_drained();
            repeat (8) @(posedge clk);
            value = (phase_exp[ph] < 0) ? $urandom_range(1, 65535) : phase_exp[ph];
            write_exponent(EXP_W'(value));
            run_random(phase_len[ph]);
        end

        wait_drained();
        repeat (100) @(posedge clk);
        if (key_sb.errors == 0 && key_sb.expected_q.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
hdl/rkd_pkg.sv
hdl/rkd_div_unit.sv
hdl/rsa_key_derivation_core.sv
dv/tb_rsa_key_derivation_core.sv
